// ===== hw/rtl/sync_length_xor_frame_receiver_unit_assert.svh =====
// Assertion macros used by the frame receiver core module.
// Each macro checks a property on the rising clock edge and is disabled
// while the asynchronous reset is active.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SXFR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SXFR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SXFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SXFR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hw/rtl/sxfr_pkg.sv =====
package sxfr_pkg;

	// Framing constants.
	localparam logic [7:0] SYNC_BYTE = 8'hA4;
	localparam logic [7:0] BROADCAST_ID = 8'h4E;
	localparam logic [8:0] MAX_FRAME_LEN_RST = 9'd80;

	// Kinds of reported events.
	typedef enum logic [2:0] {
		EV_DATA      = 3'd0,
		EV_GOOD      = 3'd1,
		EV_CHK_ERR   = 3'd2,
		EV_TOO_LONG  = 3'd3,
		EV_NO_SYNC   = 3'd4
	} event_kind_t;

	// One result as it travels from the decoder to the output register.
	typedef struct packed {
		event_kind_t kind;
		logic [7:0] value;
		logic [7:0] index;
		logic [7:0] id;
		logic [7:0] len;
		logic [7:0] rate;
		logic changed;
	} result_t;

endpackage

// ===== hw/rtl/sxfr_core.sv =====
`include "sync_length_xor_frame_receiver_unit_assert.svh"

module sxfr_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [8:0] cfg_wdata,
	input logic step,
	input logic [7:0] byte_in,
	output logic res_valid,
	output sxfr_pkg::result_t res
);

	logic [8:0] max_len_q;
	logic [8:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] xor_q;
	logic [7:0] id_q;
	logic [7:0] last_q;
	logic [7:0] rate_q;

	logic [8:0] pos_d;
	logic [7:0] len_d;
	logic [7:0] xor_d;
	logic [7:0] id_d;
	logic [7:0] last_d;
	logic [7:0] rate_d;

	logic [9:0] body_end;
	logic [9:0] frame_total;
	logic [8:0] idx_full;

	assign body_end = {2'b00, len_q} + 10'd3;
	assign frame_total = {2'b00, len_q} + 10'd4;
	assign idx_full = pos_q - 9'd3;

	// Next-state and result decode for the byte in the input stage.
	always_comb begin
		pos_d = pos_q;
		len_d = len_q;
		xor_d = xor_q;
		id_d = id_q;
		last_d = last_q;
		rate_d = rate_q;
		res_valid = 1'b0;
		res.kind = sxfr_pkg::EV_DATA;
		res.value = byte_in;
		res.index = 8'd0;
		res.id = id_q;
		res.len = len_q;
		res.rate = rate_q;
		res.changed = 1'b0;
		priority if (pos_q == 9'd0) begin
			if (byte_in == sxfr_pkg::SYNC_BYTE) begin
				xor_d = byte_in;
				pos_d = 9'd1;
			end else begin
				res_valid = 1'b1;
				res.kind = sxfr_pkg::EV_NO_SYNC;
				res.id = 8'd0;
				res.len = 8'd0;
			end
		end else if (pos_q == 9'd1) begin
			len_d = byte_in;
			xor_d = xor_q ^ byte_in;
			pos_d = 9'd2;
		end else if ({1'b0, pos_q} < body_end) begin
			xor_d = xor_q ^ byte_in;
			last_d = byte_in;
			pos_d = pos_q + 9'd1;
			if (pos_q == 9'd2) begin
				id_d = byte_in;
			end else begin
				res_valid = 1'b1;
				res.index = idx_full[7:0];
			end
		end else begin
			// Checksum byte closes the frame.
			pos_d = 9'd0;
			res_valid = 1'b1;
			priority if (frame_total > {1'b0, max_len_q}) begin
				res.kind = sxfr_pkg::EV_TOO_LONG;
			end else if (xor_q != byte_in) begin
				res.kind = sxfr_pkg::EV_CHK_ERR;
			end else begin
				res.kind = sxfr_pkg::EV_GOOD;
				if (id_q == sxfr_pkg::BROADCAST_ID && rate_q != last_q) begin
					rate_d = last_q;
					res.rate = last_q;
					res.changed = 1'b1;
				end
			end
		end
	end

	// Frame state advances once per byte leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 9'd0;
			len_q <= 8'd0;
			xor_q <= 8'd0;
			id_q <= 8'd0;
			last_q <= 8'd0;
			rate_q <= 8'd0;
		end else if (step) begin
			pos_q <= pos_d;
			len_q <= len_d;
			xor_q <= xor_d;
			id_q <= id_d;
			last_q <= last_d;
			rate_q <= rate_d;
		end
	end

	// Frame length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= sxfr_pkg::MAX_FRAME_LEN_RST;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Inside the body the position never runs past the checksum slot.
	`SXFR_ASSERT(a_pos_bound, clk, arst_n, (pos_q >= 9'd2) |-> ({1'b0, pos_q} <= body_end), "byte position beyond checksum slot")
	// Every end-of-frame report sends the decoder back to sync hunting.
	`SXFR_ASSERT(a_eof_idle, clk, arst_n, (step && res_valid && (res.kind == sxfr_pkg::EV_GOOD || res.kind == sxfr_pkg::EV_CHK_ERR || res.kind == sxfr_pkg::EV_TOO_LONG)) |=> (pos_q == 9'd0), "decoder not idle after frame end")
	// A rate change is only flagged on a good broadcast frame.
	`SXFR_ASSERT_NEVER(a_chg_good, clk, arst_n, res.changed && (res.kind != sxfr_pkg::EV_GOOD || id_q != sxfr_pkg::BROADCAST_ID), "rate change outside good broadcast frame")

endmodule

// ===== hw/rtl/sync_length_xor_frame_receiver_unit.sv =====
// Channel   | Handshake               | Payload
// ----------+-------------------------+-------------------------------------------
// input     | in_valid / in_ready     | rx_byte
// output    | out_valid / out_ready   | event_kind, data_value, data_index,
//           |                         | message_id, frame_length, heart_rate,
//           |                         | heart_rate_changed
// config    | cfg_we                  | cfg_wdata (frame length limit)
//
// Each byte is held in the input register and, if it causes a report, its
// result is registered in the output register; one byte per cycle is
// sustained while out_ready holds, set by the single decode step.
// Reset clears the frame state to sync hunting and sets the limit to 80.
// While a report waits on out_ready the input register holds its byte and
// in_ready drops only once that register is also occupied.

module sync_length_xor_frame_receiver_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	input logic cfg_we,
	input logic [8:0] cfg_wdata,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] event_kind,
	output logic [7:0] data_value,
	output logic [7:0] data_index,
	output logic [7:0] message_id,
	output logic [7:0] frame_length,
	output logic [7:0] heart_rate,
	output logic heart_rate_changed
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic step;
	logic res_valid;
	sxfr_pkg::result_t res;
	sxfr_pkg::result_t res_s2;
	logic valid_s2;

	// A byte leaves the input stage when the output register can take a result.
	assign step = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	sxfr_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.step(step),
		.byte_in(byte_s1),
		.res_valid(res_valid),
		.res(res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign event_kind = res_s2.kind;
	assign data_value = res_s2.value;
	assign data_index = res_s2.index;
	assign message_id = res_s2.id;
	assign frame_length = res_s2.len;
	assign heart_rate = res_s2.rate;
	assign heart_rate_changed = res_s2.changed;

endmodule
